// ===== design/mpdp_pkg.sv =====
// Package for the mixed-precision packed dot product unit.
// Holds the request and result payload types, width codes and configuration indexes.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package mpdp_pkg;

  localparam int WORD_BITS_DEF  = 64;
  localparam int SUM_BITS       = 32;
  localparam int FIELD_BITS     = 64;
  localparam int COUNT_BITS     = 6;
  localparam int SEL_BITS       = 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int GROUP_LANES    = 8;

  // Element width codes shared by both vectors.
  typedef enum logic [SEL_BITS-1:0] {
    W16 = 2'd0,
    W8  = 2'd1,
    W4  = 2'd2,
    W2  = 2'd3
  } width_sel_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_A_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_B_WIDTH = 1'b1;

  typedef struct packed {
    logic [FIELD_BITS-1:0] a_word;
    logic [FIELD_BITS-1:0] b_word;
    logic [COUNT_BITS-1:0] valid_count;
    logic                  last_word;
  } in_req_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] dot_sum;
    logic                       bad_mode;
  } out_res_t;

  // Control that travels with a word through the lane stage.
  typedef struct packed {
    logic valid;
    logic last;
    logic bad;
  } stage_ctrl_t;

endpackage

// ===== design/mixed_precision_packed_dot_product_unit.sv =====
// Top level of the mixed-precision packed dot product unit.
// Instantiates mpdp_lane (one per element slot) and mpdp_merge; uses mpdp_pkg.
`timescale 1ns / 1ps

// Usage
// The block accumulates a signed dot product of two packed vectors. Each request
// on the in channel (in_valid / in_ready / in_data) carries one word of a, the
// matching low-aligned elements of b, a count of valid element pairs and a
// last-word flag. Element widths come from two registers written through the
// plain write port (cfg_we, cfg_index, cfg_data): index 0 sets a, index 1 sets
// b, coded 0=16, 1=8, 2=4, 3=2 bits. Both reset to 8 bits. Registers should be
// written only while no request is in flight.
// A request marked last produces one result on the res channel: the wrapped
// 32-bit sum of all products since the previous result, and bad_mode, set when
// any word of that vector ran with b wider than a (such words add nothing).
// An accepted request moves through the lane multiply stage, the registered
// group sums, and then the accumulator and the result register, which
// raises res_valid. Throughput is one request per cycle as long as the
// res channel does not stall. When the receiver stalls,
// requests keep flowing until a second last word reaches the accumulate stage
// while the first result still waits; then the two upstream stages fill and
// in_ready drops. Synchronous reset clears the running sum, the error flag and
// all valid bits, and sets both widths back to 8 bits.

module mixed_precision_packed_dot_product_unit import mpdp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_req_t                   in_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output out_res_t                  res,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SEL_BITS-1:0]       cfg_data
);

  localparam int NUM_LANES = WORD_BITS / 2;
  localparam logic [COUNT_BITS-1:0] LANES16 = COUNT_BITS'(WORD_BITS / 16);
  localparam logic [COUNT_BITS-1:0] LANES8  = COUNT_BITS'(WORD_BITS / 8);
  localparam logic [COUNT_BITS-1:0] LANES4  = COUNT_BITS'(WORD_BITS / 4);
  localparam logic [COUNT_BITS-1:0] LANES2  = COUNT_BITS'(WORD_BITS / 2);

  width_sel_t                 a_sel;
  width_sel_t                 b_sel;
  logic [COUNT_BITS-1:0]      max_lanes;
  logic                       bad;
  logic                       s2_free;
  logic                       s1_free;
  stage_ctrl_t                s1;
  logic signed [SUM_BITS-1:0] prod [NUM_LANES];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_sel <= W8;
      b_sel <= W8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_A_WIDTH: a_sel <= width_sel_t'(cfg_data);
        CFG_B_WIDTH: b_sel <= width_sel_t'(cfg_data);
      endcase
    end
  end

  // The number of element slots in a word depends on the width of a; a count
  // above it is clipped by the per-lane compare below.
  always_comb begin
    unique case (a_sel)
      W16: max_lanes = LANES16;
      W8:  max_lanes = LANES8;
      W4:  max_lanes = LANES4;
      W2:  max_lanes = LANES2;
    endcase
  end

  // Code order runs from wide to narrow, so a smaller b code means b is wider.
  assign bad = SEL_BITS'(b_sel) < SEL_BITS'(a_sel);

  // The lane stage moves whenever the merge stage can take its contents.
  assign s1_free  = !s1.valid || s2_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1.last <= in_data.last_word;
      s1.bad  <= bad;
    end
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (s1_free) begin
      s1.valid <= in_valid;
    end
  end

  // Each lane sees the windows of both words at all four widths; windows that
  // fall outside the word are tied off, since such a lane is never enabled at
  // that width.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic [15:0] a16;
    logic [7:0]  a8;
    logic [3:0]  a4;
    logic [1:0]  a2;
    logic [15:0] b16;
    logic [7:0]  b8;
    logic [3:0]  b4;
    logic [1:0]  b2;
    logic        lane_on;

    if ((i + 1) * 16 <= WORD_BITS) begin : g_w16
      assign a16 = in_data.a_word[i*16 +: 16];
      assign b16 = in_data.b_word[i*16 +: 16];
    end else begin : g_n16
      assign a16 = '0;
      assign b16 = '0;
    end

    if ((i + 1) * 8 <= WORD_BITS) begin : g_w8
      assign a8 = in_data.a_word[i*8 +: 8];
      assign b8 = in_data.b_word[i*8 +: 8];
    end else begin : g_n8
      assign a8 = '0;
      assign b8 = '0;
    end

    if ((i + 1) * 4 <= WORD_BITS) begin : g_w4
      assign a4 = in_data.a_word[i*4 +: 4];
      assign b4 = in_data.b_word[i*4 +: 4];
    end else begin : g_n4
      assign a4 = '0;
      assign b4 = '0;
    end

    assign a2 = in_data.a_word[i*2 +: 2];
    assign b2 = in_data.b_word[i*2 +: 2];

    assign lane_on = (COUNT_BITS'(i) < in_data.valid_count)
                     && (COUNT_BITS'(i) < max_lanes) && !bad;

    mpdp_lane u_lane (
      .clk     (clk),
      .en      (s1_free),
      .lane_on (lane_on),
      .a_sel   (a_sel),
      .b_sel   (b_sel),
      .a16     (a16),
      .a8      (a8),
      .a4      (a4),
      .a2      (a2),
      .b16     (b16),
      .b8      (b8),
      .b4      (b4),
      .b2      (b2),
      .prod    (prod[i])
    );
  end

  mpdp_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .prod      (prod),
    .s1        (s1),
    .s2_free   (s2_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== design/mpdp_lane.sv =====
// One multiply lane: picks element i of a and b at the configured widths,
// sign-extends both to 16 bits and registers their product. Uses mpdp_pkg.
`timescale 1ns / 1ps

module mpdp_lane import mpdp_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       lane_on,
  input  width_sel_t                 a_sel,
  input  width_sel_t                 b_sel,
  input  logic [15:0]                a16,
  input  logic [7:0]                 a8,
  input  logic [3:0]                 a4,
  input  logic [1:0]                 a2,
  input  logic [15:0]                b16,
  input  logic [7:0]                 b8,
  input  logic [3:0]                 b4,
  input  logic [1:0]                 b2,
  output logic signed [SUM_BITS-1:0] prod
);

  logic signed [15:0]         av;
  logic signed [15:0]         bv;
  logic signed [SUM_BITS-1:0] mul;

  always_comb begin
    unique case (a_sel)
      W16: av = a16;
      W8:  av = {{8{a8[7]}}, a8};
      W4:  av = {{12{a4[3]}}, a4};
      W2:  av = {{14{a2[1]}}, a2};
    endcase
  end

  always_comb begin
    unique case (b_sel)
      W16: bv = b16;
      W8:  bv = {{8{b8[7]}}, b8};
      W4:  bv = {{12{b4[3]}}, b4};
      W2:  bv = {{14{b2[1]}}, b2};
    endcase
  end

  assign mul = av * bv;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= lane_on ? mul : '0;
    end
  end

endmodule

// ===== design/mpdp_merge.sv =====
// Merging stage: adds lane products in registered groups of eight, then folds
// the group sums into the running sum and holds the result register. Uses mpdp_pkg.
`timescale 1ns / 1ps

module mpdp_merge import mpdp_pkg::*; #(
  parameter int NUM_LANES = WORD_BITS_DEF / 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SUM_BITS-1:0] prod [NUM_LANES],
  input  stage_ctrl_t                s1,
  output logic                       s2_free,
  output logic                       res_valid,
  input  logic                       res_ready,
  output out_res_t                   res
);

  localparam int NUM_GROUPS = (NUM_LANES + GROUP_LANES - 1) / GROUP_LANES;

  logic [SUM_BITS-1:0] part      [NUM_GROUPS];
  logic [SUM_BITS-1:0] part_q    [NUM_GROUPS];
  stage_ctrl_t         s2;
  logic [SUM_BITS-1:0] acc;
  logic                err_seen;
  logic [SUM_BITS-1:0] total;
  logic                err_total;
  logic                out_free;
  logic                acc_go;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part[g] = '0;
      for (int k = 0; k < GROUP_LANES; k++) begin
        if (g * GROUP_LANES + k < NUM_LANES) begin
          part[g] = part[g] + prod[g * GROUP_LANES + k];
        end
      end
    end
  end

  always_comb begin
    total = acc;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total = total + part_q[g];
    end
  end

  assign err_total = err_seen | s2.bad;
  assign out_free  = !res_valid || res_ready;
  // A last word may only fold in when the result register can take it.
  assign acc_go    = s2.valid && (!s2.last || out_free);
  assign s2_free   = !s2.valid || acc_go;

  always_ff @(posedge clk) begin
    if (s2_free) begin
      part_q <= part;
      s2.last <= s1.last;
      s2.bad  <= s1.bad;
    end
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (s2_free) begin
      s2.valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      err_seen  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (acc_go) begin
        if (s2.last) begin
          res_valid <= 1'b1;
          acc       <= '0;
          err_seen  <= 1'b0;
        end else begin
          acc      <= total;
          err_seen <= err_total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_go && s2.last) begin
      res.dot_sum  <= total;
      res.bad_mode <= err_total;
    end
  end

endmodule
